@@ hw/rtl/gim_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gim_pkg
// Shared constants and types for the geophone impedance magnitude block.
// ----------------------------------------------------------------------------
package gim_pkg;

  localparam int OUT_WIDTH = 20;

  // datapath width of the wide products, digit width of the multiplier cells
  localparam int BW  = 240;
  localparam int DIG = 8;

  // multiplier cell rows: first row covers 56-bit operands, second 120-bit
  localparam int NA = 7;
  localparam int NB = 15;

  // quotient bits and root bits
  localparam int QW = 2 * OUT_WIDTH + 2;
  localparam int RW = OUT_WIDTH + 1;

  localparam logic [26:0] TWO_PI_Q = 27'd105414357;
  localparam logic [19:0] MICRO    = 20'd1000000;

  typedef logic [BW-1:0] wide_t;

  typedef struct packed {
    logic valid;
    logic zero;
    logic ovf;
  } ctl_t;

endpackage

@@ hw/rtl/gim_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gim_in_if / gim_out_if
// Valid/ready channels for parameter sets and impedance results.
// ----------------------------------------------------------------------------
interface gim_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] drive_freq;
  logic [15:0] natural_freq;
  logic [15:0] sensitivity;
  logic [19:0] moving_mass;
  logic [15:0] damping_ratio;
  logic [19:0] coil_resistance;

  modport source (
    output valid, drive_freq, natural_freq, sensitivity, moving_mass,
           damping_ratio, coil_resistance,
    input  ready
  );
  modport sink (
    input  valid, drive_freq, natural_freq, sensitivity, moving_mass,
           damping_ratio, coil_resistance,
    output ready
  );
endinterface

interface gim_out_if import gim_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUT_WIDTH-1:0] impedance_ohms;
  logic                 no_result;
  logic                 saturated;

  modport source (
    output valid, impedance_ohms, no_result, saturated,
    input  ready
  );
  modport sink (
    input  valid, impedance_ohms, no_result, saturated,
    output ready
  );
endinterface

@@ hw/rtl/gim_mul_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gim_mul_cell
// One digit of a shift-add multiplier row: add a times the low digit of b,
// then hand a shifted up and b shifted down to the next cell.
// ----------------------------------------------------------------------------
module gim_mul_cell import gim_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  wide_t acc_i,
  input  wide_t a_i,
  input  wide_t b_i,
  output wide_t acc_o,
  output wide_t a_o,
  output wide_t b_o
);

  wide_t acc_q, a_q, b_q;
  wide_t acc_d;

  assign acc_d = acc_i + wide_t'(a_i * {{(BW-DIG){1'b0}}, b_i[DIG-1:0]});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
      a_q   <= a_i << DIG;
      b_q   <= b_i >> DIG;
    end
  end

  assign acc_o = acc_q;
  assign a_o   = a_q;
  assign b_o   = b_q;

endmodule

@@ hw/rtl/gim_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gim_div_cell
// One restoring division step: bring in the next numerator bit, subtract
// the divisor when it fits, shift the quotient bit in.
// ----------------------------------------------------------------------------
module gim_div_cell import gim_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  wide_t         pr_i,
  input  logic [QW-1:0] nb_i,
  input  logic [QW-1:0] q_i,
  input  wide_t         den_i,
  output wide_t         pr_o,
  output logic [QW-1:0] nb_o,
  output logic [QW-1:0] q_o,
  output wide_t         den_o
);

  wide_t         pr_q, den_q, cur;
  logic [QW-1:0] nb_q, q_q;
  logic          ge;

  assign cur = {pr_i[BW-2:0], nb_i[QW-1]};
  assign ge  = (cur >= den_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q  <= ge ? (cur - den_i) : cur;
      nb_q  <= nb_i << 1;
      q_q   <= {q_i[QW-2:0], ge};
      den_q <= den_i;
    end
  end

  assign pr_o  = pr_q;
  assign nb_o  = nb_q;
  assign q_o   = q_q;
  assign den_o = den_q;

endmodule

@@ hw/rtl/gim_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gim_sqrt_cell
// One digit-by-digit integer square root step over two radicand bits.
// ----------------------------------------------------------------------------
module gim_sqrt_cell import gim_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [RW:0]   rem_i,
  input  logic [RW-1:0] root_i,
  input  logic [QW-1:0] qb_i,
  output logic [RW:0]   rem_o,
  output logic [RW-1:0] root_o,
  output logic [QW-1:0] qb_o
);

  logic [RW+2:0] cur, trial, diff;
  logic [RW:0]   rem_q;
  logic [RW-1:0] root_q;
  logic [QW-1:0] qb_q;
  logic          ge;

  assign cur   = {rem_i, qb_i[QW-1:QW-2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign ge    = (cur >= trial);
  assign diff  = ge ? (cur - trial) : cur;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= diff[RW:0];
      root_q <= {root_i[RW-2:0], ge};
      qb_q   <= qb_i << 2;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign qb_o   = qb_q;

endmodule

@@ hw/rtl/geophone_impedance_magnitude.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geophone_impedance_magnitude
// Throughput one item per cycle; the whole pipeline holds while a result
// waits. Depth is set by the multiplier cell rows, the restoring divider
// row and the square root row. Reset clears the stage control flags
// (valid, zero, overrange) only.
// ----------------------------------------------------------------------------
module geophone_impedance_magnitude import gim_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  gim_in_if.sink           in_ch_i,
  gim_out_if.source        out_ch_o
);

  localparam int S1  = 1;
  localparam int S2  = S1 + 1;
  localparam int S3  = S2 + 1 + NA;
  localparam int S4  = S3 + 1 + NB;
  localparam int SO  = S4 + 1 + QW + RW;
  localparam int NST = SO + 1;

  localparam int NLA = 6;
  localparam int NLB = 3;

  logic en;
  ctl_t ctl_q [NST];
  ctl_t ctl_d [NST];

  assign en            = !ctl_q[SO].valid || out_ch_o.ready;
  assign in_ch_i.ready = en;

  // stage 0: input capture
  logic [15:0] df_q, nf_q, s_q, bt_q;
  logic [19:0] m_q, r_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      df_q <= in_ch_i.drive_freq;
      nf_q <= in_ch_i.natural_freq;
      s_q  <= in_ch_i.sensitivity;
      m_q  <= in_ch_i.moving_mass;
      bt_q <= in_ch_i.damping_ratio;
      r_q  <= in_ch_i.coil_resistance;
    end
  end

  // stage 1: small products
  logic [15:0] df1_q, nf1_q;
  logic [31:0] nf2_q, df2_q, btdf_q, s2_q;
  logic [39:0] rm_q;
  logic [50:0] tm16_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      df1_q  <= df_q;
      nf1_q  <= nf_q;
      nf2_q  <= 32'(nf_q) * 32'(nf_q);
      df2_q  <= 32'(df_q) * 32'(df_q);
      btdf_q <= 32'(bt_q) * 32'(df_q);
      s2_q   <= 32'(s_q) * 32'(s_q);
      rm_q   <= 40'(r_q) * 40'(m_q);
      tm16_q <= {47'(47'(TWO_PI_Q) * 47'(m_q)), 4'b0000};
    end
  end

  // stage 2: U, V and the remaining narrow factors
  logic [42:0] u_q;
  logic [47:0] vv_q, s2df_q;
  logic [66:0] rmt_q;
  logic [50:0] tm16b_q;
  logic [31:0] au;

  assign au = (nf2_q >= df2_q) ? (nf2_q - df2_q) : (df2_q - nf2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q     <= {au, 11'b0};
      vv_q    <= 48'(btdf_q) * 48'(nf1_q);
      s2df_q  <= 48'(s2_q) * 48'(df1_q);
      rmt_q   <= 67'(rm_q) * 67'(TWO_PI_Q);
      tm16b_q <= tm16_q;
    end
  end

  // first multiplier row
  wide_t acc_a [NA+1][NLA];
  wide_t a_a   [NA+1][NLA];
  wide_t b_a   [NA+1][NLA];

  for (genvar l = 0; l < NLA; l++) begin : g_acc_a
    assign acc_a[0][l] = '0;
  end

  assign a_a[0][0] = wide_t'(rmt_q);
  assign b_a[0][0] = wide_t'(vv_q);
  assign a_a[0][1] = wide_t'(rmt_q);
  assign b_a[0][1] = wide_t'(u_q);
  assign a_a[0][2] = wide_t'(s2df_q);
  assign b_a[0][2] = wide_t'(MICRO);
  assign a_a[0][3] = wide_t'(u_q);
  assign b_a[0][3] = wide_t'(u_q);
  assign a_a[0][4] = wide_t'(vv_q);
  assign b_a[0][4] = wide_t'(vv_q);
  assign a_a[0][5] = wide_t'(tm16b_q);
  assign b_a[0][5] = wide_t'(tm16b_q);

  for (genvar c = 0; c < NA; c++) begin : g_row_a
    for (genvar l = 0; l < NLA; l++) begin : g_lane
      gim_mul_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .acc_i (acc_a[c][l]),
        .a_i   (a_a[c][l]),
        .b_i   (b_a[c][l]),
        .acc_o (acc_a[c+1][l]),
        .a_o   (a_a[c+1][l]),
        .b_o   (b_a[c+1][l])
      );
    end
  end

  // stage 3: assemble X, Y, U^2 + V^2, D^2
  wide_t x_q, y_q, w2_q, d2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q  <= acc_a[NA][0] + (acc_a[NA][2] << 27);
      y_q  <= acc_a[NA][1];
      w2_q <= acc_a[NA][3] + acc_a[NA][4];
      d2_q <= acc_a[NA][5];
    end
  end

  // second multiplier row
  wide_t acc_b [NB+1][NLB];
  wide_t a_b   [NB+1][NLB];
  wide_t b_b   [NB+1][NLB];

  for (genvar l = 0; l < NLB; l++) begin : g_acc_b
    assign acc_b[0][l] = '0;
  end

  assign a_b[0][0] = x_q;
  assign b_b[0][0] = x_q;
  assign a_b[0][1] = y_q;
  assign b_b[0][1] = y_q;
  assign a_b[0][2] = w2_q;
  assign b_b[0][2] = d2_q;

  for (genvar c = 0; c < NB; c++) begin : g_row_b
    for (genvar l = 0; l < NLB; l++) begin : g_lane
      gim_mul_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .acc_i (acc_b[c][l]),
        .a_i   (a_b[c][l]),
        .b_i   (b_b[c][l]),
        .acc_o (acc_b[c+1][l]),
        .a_o   (a_b[c+1][l]),
        .b_o   (b_b[c+1][l])
      );
    end
  end

  // stage 4: numerator, divisor, overrange check
  wide_t         num4, pr_init;
  logic          ovf_d;
  wide_t         pr_q [QW+1];
  wide_t         den_q [QW+1];
  logic [QW-1:0] nb_q [QW+1];
  logic [QW-1:0] qv_q [QW+1];
  wide_t         pr0_q, den0_q;
  logic [QW-1:0] nb0_q;

  assign num4    = (acc_b[NB][0] + acc_b[NB][1]) << 2;
  assign pr_init = num4 >> QW;
  assign ovf_d   = (pr_init >= acc_b[NB][2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr0_q  <= pr_init;
      nb0_q  <= num4[QW-1:0];
      den0_q <= acc_b[NB][2];
    end
  end

  assign pr_q[0]  = pr0_q;
  assign nb_q[0]  = nb0_q;
  assign den_q[0] = den0_q;
  assign qv_q[0]  = '0;

  for (genvar c = 0; c < QW; c++) begin : g_div
    gim_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .pr_i  (pr_q[c]),
      .nb_i  (nb_q[c]),
      .q_i   (qv_q[c]),
      .den_i (den_q[c]),
      .pr_o  (pr_q[c+1]),
      .nb_o  (nb_q[c+1]),
      .q_o   (qv_q[c+1]),
      .den_o (den_q[c+1])
    );
  end

  // square root row
  logic [RW:0]   rem_s  [RW+1];
  logic [RW-1:0] root_s [RW+1];
  logic [QW-1:0] qb_s   [RW+1];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign qb_s[0]   = qv_q[QW];

  for (genvar c = 0; c < RW; c++) begin : g_sqrt
    gim_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (rem_s[c]),
      .root_i (root_s[c]),
      .qb_i   (qb_s[c]),
      .rem_o  (rem_s[c+1]),
      .root_o (root_s[c+1]),
      .qb_o   (qb_s[c+1])
    );
  end

  // output stage: round to nearest, saturate
  logic [RW:0]          n_full;
  logic [RW-1:0]        n_ohm;
  logic                 sat;
  logic [OUT_WIDTH-1:0] imp_q;
  logic                 nores_q, sat_q;

  assign n_full = ({1'b0, root_s[RW]} + (RW+1)'(1)) >> 1;
  assign n_ohm  = n_full[RW-1:0];
  assign sat    = ctl_q[SO-1].ovf || n_ohm[OUT_WIDTH];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (ctl_q[SO-1].zero) begin
        imp_q   <= '0;
        nores_q <= 1'b1;
        sat_q   <= 1'b0;
      end else begin
        imp_q   <= sat ? {OUT_WIDTH{1'b1}} : n_ohm[OUT_WIDTH-1:0];
        nores_q <= 1'b0;
        sat_q   <= sat;
      end
    end
  end

  // control pipe
  always_comb begin
    ctl_d[0].valid = in_ch_i.valid;
    ctl_d[0].zero  = (in_ch_i.drive_freq == '0) || (in_ch_i.natural_freq == '0) ||
                     (in_ch_i.sensitivity == '0) || (in_ch_i.moving_mass == '0) ||
                     (in_ch_i.damping_ratio == '0) || (in_ch_i.coil_resistance == '0);
    ctl_d[0].ovf   = 1'b0;
    for (int i = 1; i < NST; i++) begin
      ctl_d[i] = ctl_q[i-1];
    end
    ctl_d[S4].ovf = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (en) begin
      for (int i = 0; i < NST; i++) begin
        ctl_q[i] <= ctl_d[i];
      end
    end
  end

  assign out_ch_o.valid          = ctl_q[SO].valid;
  assign out_ch_o.impedance_ohms = imp_q;
  assign out_ch_o.no_result      = nores_q;
  assign out_ch_o.saturated      = sat_q;

endmodule

@@ test/gim_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gim_tb_pkg
// Parameter set and impedance result records, the exact impedance predictor
// and the scoreboard that matches predicted against returned results.
// ----------------------------------------------------------------------------
package gim_tb_pkg;
  import gim_pkg::*;

  typedef logic [319:0] bignum_t;

  typedef struct {
    logic [15:0] df;
    logic [15:0] nf;
    logic [15:0] s;
    logic [19:0] m;
    logic [15:0] bt;
    logic [19:0] r;
  } geo_params_t;

  typedef struct {
    logic [OUT_WIDTH-1:0] ohms;
    logic                 nores;
    logic                 sat;
  } impedance_t;

  // true when the magnitude rounds to at least n
  function automatic bit rounds_to(longint unsigned n, bignum_t num4, bignum_t den);
    bignum_t k;
    if (n == 0) return 1'b1;
    k = bignum_t'(2 * n - 1);
    return (k * k * den) <= num4;
  endfunction

  function automatic impedance_t predict_impedance(geo_params_t p);
    impedance_t res;
    longint unsigned au, uu, vv, maxv, lo, hi, mid;
    bignum_t a, bq, num4, e, den;
    maxv = (64'd1 << OUT_WIDTH) - 1;
    res = '{ohms: '0, nores: 1'b0, sat: 1'b0};
    if (p.df == 0 || p.nf == 0 || p.s == 0 || p.m == 0 || p.bt == 0 || p.r == 0) begin
      res.nores = 1'b1;
      return res;
    end
    au = (p.nf >= p.df) ? (64'(p.nf) * p.nf - 64'(p.df) * p.df)
                        : (64'(p.df) * p.df - 64'(p.nf) * p.nf);
    uu = au << 11;
    vv = 64'(p.bt) * p.df * p.nf;
    a  = bignum_t'(vv) * p.r * TWO_PI_Q * p.m
       + bignum_t'(p.s) * p.s * p.df * MICRO * (bignum_t'(1) << 27);
    bq = bignum_t'(uu) * p.r * TWO_PI_Q * p.m;
    num4 = (a * a + bq * bq) * 4;
    e = bignum_t'(TWO_PI_Q) * p.m * 16;
    den = e * e * (bignum_t'(uu) * uu + bignum_t'(vv) * vv);
    if (rounds_to(maxv + 1, num4, den)) begin
      res.ohms = maxv[OUT_WIDTH-1:0];
      res.sat  = 1'b1;
      return res;
    end
    lo = 0;
    hi = maxv;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (rounds_to(mid, num4, den)) lo = mid;
      else hi = mid - 1;
    end
    res.ohms = lo[OUT_WIDTH-1:0];
    return res;
  endfunction

  class impedance_scoreboard;
    impedance_t pending[$];
    int errors = 0;

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    function void note_params(geo_params_t p);
      pending.push_back(predict_impedance(p));
    endfunction

    task check_result(impedance_t got);
      impedance_t want;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      want = pending.pop_front();
      if (got.ohms !== want.ohms)
        report($sformatf("impedance_ohms %0d, want %0d", got.ohms, want.ohms));
      if (got.nores !== want.nores)
        report($sformatf("no_result %b, want %b", got.nores, want.nores));
      if (got.sat !== want.sat)
        report($sformatf("saturated %b, want %b", got.sat, want.sat));
    endtask
  endclass

endpackage

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives geophone parameter sets through the impedance magnitude block with
// random gaps and stalls, and checks each result against an exact predictor.
// ----------------------------------------------------------------------------
module testbench;
  import gim_pkg::*;
  import gim_tb_pkg::*;

  logic clk;
  logic rst_n;
  int   hold_request = 0;

  gim_in_if  in_ch ();
  gim_out_if out_ch ();

  impedance_scoreboard sb = new();

  geophone_impedance_magnitude DUT (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 65) return 0;
    if (pick < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [19:0] pick_field(int bits);
    int pick;
    logic [19:0] maxv;
    maxv = 20'((32'd1 << bits) - 32'd1);
    pick = $urandom_range(99);
    if (pick < 3) return '0;
    if (pick < 13) return maxv;
    if (pick < 30) return 20'($urandom_range(16, 1));
    return 20'($urandom) & maxv;
  endfunction

  function automatic geo_params_t random_params();
    geo_params_t p;
    p.df = 16'(pick_field(16));
    p.nf = ($urandom_range(9) == 0) ? p.df : 16'(pick_field(16));
    p.s  = 16'(pick_field(16));
    p.m  = pick_field(20);
    p.bt = 16'(pick_field(16));
    p.r  = pick_field(20);
    return p;
  endfunction

  task automatic send_params(geo_params_t p);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.drive_freq      = p.df;
    in_ch.natural_freq    = p.nf;
    in_ch.sensitivity     = p.s;
    in_ch.moving_mass     = p.m;
    in_ch.damping_ratio   = p.bt;
    in_ch.coil_resistance = p.r;
    in_ch.valid           = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_fields(logic [15:0] df, logic [15:0] nf, logic [15:0] s,
                             logic [19:0] m, logic [15:0] bt, logic [19:0] r);
    geo_params_t p;
    p = '{df: df, nf: nf, s: s, m: m, bt: bt, r: r};
    send_params(p);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int g;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        out_ch.ready = 1'b0;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
      end
      g = gap_len();
      if (g > 0) begin
        out_ch.ready = 1'b0;
        repeat (g - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    geo_params_t p;
    impedance_t got;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      p = '{df: in_ch.drive_freq, nf: in_ch.natural_freq, s: in_ch.sensitivity,
            m: in_ch.moving_mass, bt: in_ch.damping_ratio, r: in_ch.coil_resistance};
      sb.note_params(p);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{ohms: out_ch.impedance_ohms, nores: out_ch.no_result,
              sat: out_ch.saturated};
      sb.check_result(got);
    end
  end

  initial begin
    in_ch.valid           = 1'b0;
    in_ch.drive_freq      = '0;
    in_ch.natural_freq    = '0;
    in_ch.sensitivity     = '0;
    in_ch.moving_mass     = '0;
    in_ch.damping_ratio   = '0;
    in_ch.coil_resistance = '0;
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_fields(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 20'hFFFFF);
    send_fields(16'd1, 16'd1, 16'd1, 20'd1, 16'd1, 20'd1);
    send_fields(16'd0, 16'd160, 16'd7000, 20'd11000, 16'd2900, 20'd6000);
    send_fields(16'd800, 16'd0, 16'd7000, 20'd11000, 16'd2900, 20'd6000);
    send_fields(16'd800, 16'd160, 16'd0, 20'd11000, 16'd2900, 20'd6000);
    send_fields(16'd800, 16'd160, 16'd7000, 20'd0, 16'd2900, 20'd6000);
    send_fields(16'd800, 16'd160, 16'd7000, 20'd11000, 16'd0, 20'd6000);
    send_fields(16'd800, 16'd160, 16'd7000, 20'd11000, 16'd2900, 20'd0);
    send_fields('0, '0, '0, '0, '0, '0);
    send_fields(16'd160, 16'd160, 16'd7000, 20'd11000, 16'd2900, 20'd6000);
    send_fields(16'hFFFF, 16'hFFFF, 16'd1, 20'hFFFFF, 16'd1, 20'd1);
    send_fields(16'd800, 16'd160, 16'd7000, 20'd11000, 16'd2900, 20'd6000);
    send_fields(16'd1, 16'hFFFF, 16'hFFFF, 20'd1, 16'd1, 20'hFFFFF);
    send_fields(16'hFFFF, 16'd1, 16'hFFFF, 20'd1, 16'd1, 20'hFFFFF);
    send_fields(16'd1, 16'd1, 16'd1, 20'hFFFFF, 16'hFFFF, 20'd1);
    send_fields(16'd160, 16'd161, 16'hFFFF, 20'd1, 16'd1, 20'd16);
    send_fields(16'd8, 16'd8, 16'd1, 20'd1000, 16'd4096, 20'd8);

    for (int i = 0; i < 1350; i++) begin
      if (i == 300) hold_request = 400;
      if (i == 700) begin
        in_ch.valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
      end
      send_params(random_params());
    end
    in_ch.valid = 1'b0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    if (sb.errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
